// ----- hw/rtl/ifps_pkg.sv -----
// Shared types and constants for the initial frame pair selector.
package ifps_pkg;

    localparam int MAX_FRAMES   = 16;
    localparam int WORD_BITS    = 32;
    localparam int ROW_WORDS    = 32;
    localparam int FRAME_W      = 4;
    localparam int WIDX_W       = 5;
    localparam int CNT_W        = 5;
    localparam int SCORE_W      = 15;
    localparam int DEPTH_W      = 32;
    localparam int TRACK_ADDR_W = FRAME_W + WIDX_W;
    localparam int PAIR_ADDR_W  = 2 * FRAME_W;
    localparam int GROUPS       = 8;
    localparam int GROUP_LANES  = WORD_BITS / GROUPS;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [4:0]  FRAME_LIMIT = 5'd16;
    localparam logic [10:0] POINT_LIMIT = 11'd1024;

    typedef enum logic [1:0] {
        CMD_LOAD_TRACK = 2'd0,
        CMD_LOAD_DEPTH = 2'd1,
        CMD_RUN        = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_POINT_COUNT = 2'd1,
        CFG_MIN_TRACK   = 2'd2,
        CFG_MAX_DEPTH   = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_SETTLE,
        ST_PAIR,
        ST_DRAIN,
        ST_DEFAULT,
        ST_DFLT_READ,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/ifps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ifps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/initial_frame_pair_select_top.sv -----
// Top level of the initial frame pair selector: loads, track counting and pair search.
//
//  Channel  Direction  Handshake             Payload
//  s_       in         s_tvalid / s_tready   s_tuser = cmd, s_tdata = load fields
//  m_       out        m_tvalid / m_tready   m_tuser = found, m_tdata = chosen pair
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A run walks F*W count words, settles, walks P*W pair words and drains, with F
// frames in use, P = F*(F-1)/2 pairs and W = ceil(points/32) words (at least 1);
// a default pair is read when no pair qualifies or fewer than two frames are in use.
// The single read port per track memory copy sets one word per cycle.
// After reset a clearing pass zeroes all 512 track memory words; s_tready stays low.
// A result waits in the output register; the next item is taken meanwhile, and a
// later run holds in its final state until that register is free.
module initial_frame_pair_select_top
    import ifps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // cmd
    input  logic [79:0] s_tdata,   // frame_a, frame_b, word_index, track_word, depth_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // found
    output logic [55:0] m_tdata,   // first_frame, second_frame, best_score, chosen_depth
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Input fields
    cmd_t                cmd;
    logic [FRAME_W-1:0]  in_frame_a, in_frame_b;
    logic [WIDX_W-1:0]   in_word_index;
    logic [31:0]         in_track_word;
    logic [DEPTH_W-1:0]  in_depth_value;

    assign cmd            = cmd_t'(s_tuser);
    assign in_frame_a     = s_tdata[3:0];
    assign in_frame_b     = s_tdata[7:4];
    assign in_word_index  = s_tdata[12:8];
    assign in_track_word  = s_tdata[44:13];
    assign in_depth_value = s_tdata[76:45];

    // Configuration registers
    logic [4:0]         frame_count_reg;
    logic [10:0]        point_count_reg;
    logic [SCORE_W-1:0] min_track_reg;
    logic [DEPTH_W-1:0] max_depth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= FRAME_LIMIT;
            point_count_reg <= POINT_LIMIT;
            min_track_reg   <= '0;
            max_depth_reg   <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_COUNT: frame_count_reg <= cfg_data[4:0];
                CFG_POINT_COUNT: point_count_reg <= cfg_data[10:0];
                CFG_MIN_TRACK:   min_track_reg   <= cfg_data[SCORE_W-1:0];
                CFG_MAX_DEPTH:   max_depth_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Derived limits: saturated frame and point counts, words per row
    logic [4:0]        nf;
    logic [10:0]       np;
    logic [11:0]       np_round;
    logic [5:0]        nw;
    logic [WIDX_W-1:0] last_word;
    logic [FRAME_W-1:0] last_frame;

    assign nf         = (frame_count_reg > FRAME_LIMIT) ? FRAME_LIMIT : frame_count_reg;
    assign np         = (point_count_reg > POINT_LIMIT) ? POINT_LIMIT : point_count_reg;
    assign np_round   = {1'b0, np} + 12'd31;
    assign nw         = np_round[10:5];
    assign last_word  = (nw == 6'd0) ? '0 : 5'(nw - 6'd1);
    assign last_frame = 4'(nf - 5'd1);

    // State and walk counters
    state_t             state_reg, state_next;
    logic [8:0]         clr_reg;
    logic [WIDX_W-1:0]  w_reg;
    logic [FRAME_W-1:0] f_reg, i_reg, j_reg;

    // Control signals from the output decode
    logic cnt_issue, pair_issue, word_end, frame_end, count_end, pair_end, walk_end;
    logic pipe_empty, out_free, accept;
    logic found_reg;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept && cmd == CMD_RUN) begin
                    state_next = (nf < 5'd2) ? ST_DEFAULT : ST_COUNT;
                end
            end
            ST_COUNT:     if (count_end) state_next = ST_SETTLE;
            ST_SETTLE:    state_next = ST_PAIR;
            ST_PAIR:      if (walk_end) state_next = ST_DRAIN;
            ST_DRAIN: begin
                if (pipe_empty) state_next = found_reg ? ST_DONE : ST_DEFAULT;
            end
            ST_DEFAULT:   state_next = ST_DFLT_READ;
            ST_DFLT_READ: state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Output decode
    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        cnt_issue  = (state_reg == ST_COUNT);
        pair_issue = (state_reg == ST_PAIR);
        frame_end  = (f_reg == last_frame);
        word_end   = (w_reg == last_word);
        count_end  = cnt_issue && frame_end && word_end;
        pair_end   = (j_reg == 4'(i_reg - 4'd1));
        walk_end   = pair_issue && word_end && pair_end && (i_reg == last_frame);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 9'd1;
            end
        end
    end

    // Advance walk counters: frames inside words for counting, words inside pairs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= '0;
            f_reg <= '0;
            i_reg <= 4'd1;
            j_reg <= '0;
        end else if (state_reg == ST_IDLE) begin
            w_reg <= '0;
            f_reg <= '0;
            i_reg <= 4'd1;
            j_reg <= '0;
        end else if (cnt_issue) begin
            if (frame_end) begin
                f_reg <= '0;
                w_reg <= word_end ? '0 : w_reg + 5'd1;
            end else begin
                f_reg <= f_reg + 4'd1;
            end
        end else if (pair_issue) begin
            if (word_end) begin
                w_reg <= '0;
                if (pair_end) begin
                    j_reg <= '0;
                    i_reg <= i_reg + 4'd1;
                end else begin
                    j_reg <= j_reg + 4'd1;
                end
            end else begin
                w_reg <= w_reg + 5'd1;
            end
        end
    end

    // Track memories: two copies written together, read at two rows
    logic                    trk_we;
    logic [TRACK_ADDR_W-1:0] trk_waddr, trk_raddr_a, trk_raddr_b;
    logic [WORD_BITS-1:0]    trk_wdata, trk_rdata_a, trk_rdata_b;

    assign trk_we      = (state_reg == ST_CLEAR) || (accept && cmd == CMD_LOAD_TRACK);
    assign trk_waddr   = (state_reg == ST_CLEAR) ? clr_reg : {in_frame_a, in_word_index};
    assign trk_wdata   = (state_reg == ST_CLEAR) ? '0 : in_track_word;
    assign trk_raddr_a = cnt_issue ? {f_reg, w_reg} : {i_reg, w_reg};
    assign trk_raddr_b = {j_reg, w_reg};

    ifps_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_FRAMES * ROW_WORDS)) u_track_a (
        .aclk(aclk), .we(trk_we), .waddr(trk_waddr), .wdata(trk_wdata),
        .raddr(trk_raddr_a), .rdata(trk_rdata_a)
    );

    ifps_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_FRAMES * ROW_WORDS)) u_track_b (
        .aclk(aclk), .we(trk_we), .waddr(trk_waddr), .wdata(trk_wdata),
        .raddr(trk_raddr_b), .rdata(trk_rdata_b)
    );

    // Pair depth memory
    logic                   dep_we;
    logic [PAIR_ADDR_W-1:0] dep_raddr;
    logic [DEPTH_W-1:0]     dep_rdata;

    assign dep_we    = accept && cmd == CMD_LOAD_DEPTH;
    assign dep_raddr = (state_reg == ST_DEFAULT) ? {4'd1, 4'd0} : {i_reg, j_reg};

    ifps_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_FRAMES * MAX_FRAMES)) u_depth (
        .aclk(aclk), .we(dep_we), .waddr({in_frame_a, in_frame_b}), .wdata(in_depth_value),
        .raddr(dep_raddr), .rdata(dep_rdata)
    );

    // Point count memory: one row of per-point frame counts per word
    logic                        c1_valid, c1_first, c1_last;
    logic [WIDX_W-1:0]           c1_w;
    logic [CNT_W-1:0]            lane_reg  [WORD_BITS];
    logic [CNT_W-1:0]            lane_next [WORD_BITS];
    logic [WORD_BITS*CNT_W-1:0]  cnt_wdata, cnt_rdata;

    ifps_ram #(.WIDTH(WORD_BITS * CNT_W), .DEPTH(ROW_WORDS)) u_count (
        .aclk(aclk), .we(c1_valid && c1_last), .waddr(c1_w), .wdata(cnt_wdata),
        .raddr(w_reg), .rdata(cnt_rdata)
    );

    // Count stage: add one frame's bits into the lane counters
    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            lane_next[k] = (c1_first ? '0 : lane_reg[k]) + CNT_W'(trk_rdata_a[k]);
            cnt_wdata[k*CNT_W +: CNT_W] = lane_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid <= 1'b0;
        end else begin
            c1_valid <= cnt_issue;
        end
    end

    always_ff @(posedge aclk) begin
        c1_first <= (f_reg == '0);
        c1_last  <= frame_end;
        c1_w     <= w_reg;
        if (c1_valid) begin
            lane_reg <= lane_next;
        end
    end

    // Pair pipeline, stage 1: shared bits weighted by counts, in group sums
    logic                   p1_valid, p1_first, p1_last;
    logic [FRAME_W-1:0]     p1_i, p1_j;
    logic [WIDX_W-1:0]      p1_w;
    logic [WORD_BITS-1:0]   shared;
    logic [6:0]             part_sum [GROUPS];

    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            shared[k] = trk_rdata_a[k] && trk_rdata_b[k]
                        && ({1'b0, p1_w, 5'(k)} < np);
        end
        for (int g = 0; g < GROUPS; g++) begin
            part_sum[g] = '0;
            for (int k = 0; k < GROUP_LANES; k++) begin
                part_sum[g] = part_sum[g]
                    + (shared[g*GROUP_LANES+k]
                       ? 7'(cnt_rdata[(g*GROUP_LANES+k)*CNT_W +: CNT_W]) : 7'd0);
            end
        end
    end

    // Stage 2 registers and the word total with saturating accumulate
    logic                p2_valid, p2_first, p2_last;
    logic [FRAME_W-1:0]  p2_i, p2_j;
    logic [DEPTH_W-1:0]  p2_depth;
    logic [6:0]          p2_part [GROUPS];
    logic [9:0]          word_sum;
    logic [SCORE_W:0]    acc_wide;
    logic [SCORE_W-1:0]  acc_reg, acc_next;

    always_comb begin
        word_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            word_sum = word_sum + 10'(p2_part[g]);
        end
        acc_wide = (p2_first ? '0 : {1'b0, acc_reg}) + 16'(word_sum);
        acc_next = acc_wide[SCORE_W] ? SCORE_MAX : acc_wide[SCORE_W-1:0];
    end

    // Stage 3 registers: finished pair sum
    logic                p3_valid;
    logic [FRAME_W-1:0]  p3_i, p3_j;
    logic [DEPTH_W-1:0]  p3_depth;
    logic [SCORE_W-1:0]  p3_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid <= 1'b0;
            p2_valid <= 1'b0;
            p3_valid <= 1'b0;
        end else begin
            p1_valid <= pair_issue;
            p2_valid <= p1_valid;
            p3_valid <= p2_valid && p2_last;
        end
    end

    always_ff @(posedge aclk) begin
        p1_first <= (w_reg == '0);
        p1_last  <= word_end;
        p1_i     <= i_reg;
        p1_j     <= j_reg;
        p1_w     <= w_reg;
        p2_first <= p1_first;
        p2_last  <= p1_last;
        p2_i     <= p1_i;
        p2_j     <= p1_j;
        p2_depth <= dep_rdata;
        p2_part  <= part_sum;
        if (p2_valid) begin
            acc_reg <= acc_next;
        end
        p3_i     <= p2_i;
        p3_j     <= p2_j;
        p3_depth <= p2_depth;
        p3_sum   <= acc_next;
    end

    assign pipe_empty = !p1_valid && !p2_valid && !p3_valid;

    // Best pair tracking
    logic [SCORE_W-1:0]  running_reg, best_sum_reg;
    logic [FRAME_W-1:0]  best_later_reg, best_earlier_reg;
    logic [DEPTH_W-1:0]  best_ratio_reg;
    logic                take;

    assign take = p3_valid && (p3_depth <= max_depth_reg) && (p3_sum >= running_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (state_reg == ST_IDLE) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            running_reg <= min_track_reg;
        end else if (take) begin
            running_reg      <= p3_sum;
            best_sum_reg     <= p3_sum;
            best_later_reg   <= p3_i;
            best_earlier_reg <= p3_j;
            best_ratio_reg   <= p3_depth;
        end else if (state_reg == ST_DFLT_READ) begin
            best_sum_reg     <= '0;
            best_later_reg   <= 4'd1;
            best_earlier_reg <= '0;
            best_ratio_reg   <= dep_rdata;
        end
    end

    // Output register
    logic        m_valid_reg;
    logic        m_found_reg;
    logic [55:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_found_reg <= found_reg;
            m_data_reg  <= {1'b0, best_ratio_reg, best_sum_reg,
                            best_earlier_reg, best_later_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during clearing pass");

    a_pipes_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(c1_valid && p1_valid))
        else $error("count and pair pipelines overlap");

    a_found_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && found_reg) |-> (best_later_reg > best_earlier_reg))
        else $error("chosen pair not ordered");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result overwrote pending output");

endmodule
